// File: design/assert_macros.svh
// Assertion macros shared by the odometry RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define EGO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define EGO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/ego_pkg.sv
// ----------------------------------------------------------------------------
// ego_pkg
// Types, register indexes and fixed constants of the encoder/gyro odometry.
// ----------------------------------------------------------------------------
package ego_pkg;

    typedef enum logic {
        KIND_GYRO = 1'b0,
        KIND_ENC  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [16:0] heading;
        logic [16:0] dx;
        logic [16:0] dy;
    } t_item;

    typedef struct packed {
        logic        we;
        logic [7:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

    localparam logic [7:0] REG_COUNT_CENTER = 8'd0;
    localparam logic [7:0] REG_MM_PER_COUNT = 8'd1;
    localparam logic [7:0] REG_START_X      = 8'd2;
    localparam logic [7:0] REG_START_Y      = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG_MAIN,
        ST_TRIG_OX,
        ST_TRIG_OY,
        ST_MUL,
        ST_OUT
    } t_bstate;

    // angles in Q.16 degrees
    localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [26:0] OFS_X_ANGLE  = 27'sd4818384;
    localparam logic signed [26:0] OFS_Y_ANGLE  = 27'sd10316264;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;
    localparam logic signed [17:0] OFS_X_AMP_Q8    = 18'sd31168;
    localparam logic signed [17:0] OFS_Y_AMP_Q8    = 18'sd30574;
    localparam logic signed [15:0] OFS_X_BIAS_Q4   = 16'sd3932;
    localparam logic signed [15:0] OFS_Y_BIAS_Q4   = 16'sd542;

    localparam logic [15:0]        RST_COUNT_CENTER = 16'd30000;
    localparam logic [23:0]        RST_MM_PER_COUNT = 24'd65536;
    localparam logic signed [47:0] RST_ACC_X        = 48'sd220266496;
    localparam logic signed [47:0] RST_ACC_Y        = -48'sd21692416;

    localparam logic [3:0] MUL_LAST = 4'd10;

    function automatic logic [22:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:    atan_q16 = 23'd2949120;
            5'd1:    atan_q16 = 23'd1740967;
            5'd2:    atan_q16 = 23'd919879;
            5'd3:    atan_q16 = 23'd466945;
            5'd4:    atan_q16 = 23'd234378;
            5'd5:    atan_q16 = 23'd117304;
            5'd6:    atan_q16 = 23'd58666;
            5'd7:    atan_q16 = 23'd29335;
            5'd8:    atan_q16 = 23'd14668;
            5'd9:    atan_q16 = 23'd7334;
            5'd10:   atan_q16 = 23'd3667;
            5'd11:   atan_q16 = 23'd1833;
            5'd12:   atan_q16 = 23'd917;
            5'd13:   atan_q16 = 23'd458;
            5'd14:   atan_q16 = 23'd229;
            5'd15:   atan_q16 = 23'd115;
            5'd16:   atan_q16 = 23'd57;
            5'd17:   atan_q16 = 23'd29;
            5'd18:   atan_q16 = 23'd14;
            5'd19:   atan_q16 = 23'd7;
            5'd20:   atan_q16 = 23'd4;
            5'd21:   atan_q16 = 23'd2;
            5'd22:   atan_q16 = 23'd1;
            default: atan_q16 = 23'd0;
        endcase
    endfunction

endpackage

// File: design/ego_cordic.sv
// ----------------------------------------------------------------------------
// ego_cordic
// Iterative rotation-mode CORDIC: sine and cosine of a Q.16-degree angle, Q30.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ego_cordic
    import ego_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [26:0] i_angle,
    output logic               o_done,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);

    localparam int CW = $clog2(TRIG_ITERATIONS);

    logic               r_busy;
    logic               r_done;
    logic               r_flip;
    logic [CW-1:0]      r_i;
    logic signed [33:0] r_x, r_y, n_x, n_y;
    logic signed [25:0] r_z, n_z;
    logic signed [33:0] r_sin, r_cos;

    logic signed [26:0] a1, a2, a3, a_red;
    logic               a_flip;
    logic signed [33:0] xs, ys;
    logic signed [25:0] at;

    // fold into [-90, 90] degrees
    always_comb begin
        a1     = (i_angle < 0) ? i_angle + FULL_TURN : i_angle;
        a2     = (a1 < 0) ? a1 + FULL_TURN : a1;
        a3     = (a2 >= HALF_TURN) ? a2 - FULL_TURN : a2;
        a_flip = 1'b0;
        a_red  = a3;
        if (a3 > QUARTER_TURN) begin
            a_red  = a3 - HALF_TURN;
            a_flip = 1'b1;
        end else if (a3 < -QUARTER_TURN) begin
            a_red  = a3 + HALF_TURN;
            a_flip = 1'b1;
        end
    end

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({3'b000, atan_q16(5'(r_i))});
        if (r_z >= 0) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= CORDIC_GAIN_Q30;
                r_y    <= '0;
                r_z    <= a_red[25:0];
                r_flip <= a_flip;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + CW'(1);
                if (r_i == CW'(TRIG_ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sin  <= r_flip ? -n_y : n_y;
                    r_cos  <= r_flip ? -n_x : n_x;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

    `EGO_ASSERT(a_done_after_busy, r_done |-> $past(r_busy), "cordic done without a run")

endmodule

// File: design/ego_front.sv
// ----------------------------------------------------------------------------
// ego_front
// Takes input words, re-centres the encoder counts and queues them (2 deep).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ego_front
    import ego_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // heading[16:0], count_x_raw, count_y_raw
    input  logic        s_axis_tuser,   // kind
    output t_item       o_item,
    output logic        o_item_valid,
    input  logic        i_pop
);

    logic [15:0] r_count_center;
    t_item       r_q [2];
    logic        r_rd, r_wr;
    logic [1:0]  r_count;
    logic        push;
    t_item       item;

    assign s_axis_tready = (r_count != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        item.kind    = t_kind'(s_axis_tuser);
        item.heading = s_axis_tdata[16:0];
        item.dx      = {1'b0, r_count_center} - {1'b0, s_axis_tdata[32:17]};
        item.dy      = {1'b0, s_axis_tdata[48:33]} - {1'b0, r_count_center};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_center <= RST_COUNT_CENTER;
            r_rd           <= 1'b0;
            r_wr           <= 1'b0;
            r_count        <= 2'd0;
        end else begin
            if (i_cfg.we && i_cfg.idx == REG_COUNT_CENTER) begin
                r_count_center <= i_cfg.data[15:0];
            end
            if (push) begin
                r_q[r_wr] <= item;
                r_wr      <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

    assign o_item       = r_q[r_rd];
    assign o_item_valid = (r_count != 2'd0);

    `EGO_ASSERT(a_pop_not_empty, i_pop |-> o_item_valid, "pop from empty queue")
    `EGO_ASSERT(a_count_range, r_count != 2'd3, "queue count overflow")

endmodule

// File: design/ego_back.sv
// ----------------------------------------------------------------------------
// ego_back
// Runs queued words: heading update, or CORDIC passes and shared multiplier
// steps for the accumulator update, scaling and mount offsets.
// ----------------------------------------------------------------------------
module ego_back
    import ego_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // pos_x, pos_y, pos_heading
);

    t_bstate r_state, n_state;
    logic [3:0] r_step, n_step;

    logic signed [16:0] r_heading_now, r_heading_prev;
    logic signed [47:0] r_acc_x, r_acc_y;
    logic [23:0]        r_mpc;
    logic signed [16:0] r_dx, r_dy;
    logic signed [26:0] r_ang;
    logic signed [33:0] r_s0, r_c0, r_sx, r_sy;
    logic signed [66:0] r_prod;
    logic signed [52:0] r_t1, r_t2;
    logic [59:0]        r_p1;
    logic signed [45:0] r_sc_x, r_sc_y;
    logic signed [15:0] r_off_x, r_off_y;
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic signed [16:0] r_out_h;

    logic               cs_start, cs_done;
    logic signed [26:0] cs_angle;
    logic signed [33:0] cs_sin, cs_cos;
    logic signed [17:0] hsum;
    logic signed [26:0] ang_main;
    logic               load_out;

    logic signed [48:0] mul_a;
    logic signed [17:0] mul_b;
    logic [47:0]        mag_x, mag_y;
    logic signed [52:0] t1_rnd, t2_rnd;
    logic [72:0]        wide;
    logic signed [45:0] sc_new;
    logic signed [66:0] off_rnd;
    logic signed [15:0] off_new;
    logic signed [46:0] px, py;

    ego_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_angle (cs_angle),
        .o_done  (cs_done),
        .o_sin   (cs_sin),
        .o_cos   (cs_cos)
    );

    assign hsum     = {r_heading_now[16], r_heading_now} + {r_heading_prev[16], r_heading_prev};
    assign ang_main = {{2{hsum[17]}}, hsum[17:1], 8'h00};

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        o_pop    = 1'b0;
        cs_start = 1'b0;
        cs_angle = ang_main;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    if (i_item.kind == KIND_ENC) begin
                        cs_start = 1'b1;
                        n_state  = ST_TRIG_MAIN;
                    end
                end
            end
            ST_TRIG_MAIN: begin
                cs_angle = r_ang - OFS_X_ANGLE;
                if (cs_done) begin
                    cs_start = 1'b1;
                    n_state  = ST_TRIG_OX;
                end
            end
            ST_TRIG_OX: begin
                cs_angle = r_ang - OFS_Y_ANGLE;
                if (cs_done) begin
                    cs_start = 1'b1;
                    n_state  = ST_TRIG_OY;
                end
            end
            ST_TRIG_OY: begin
                if (cs_done) begin
                    n_step  = 4'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + 4'd1;
                if (r_step == MUL_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // shared multiplier operands
    assign mag_x = r_acc_x[47] ? 48'(-r_acc_x) : 48'(r_acc_x);
    assign mag_y = r_acc_y[47] ? 48'(-r_acc_y) : 48'(r_acc_y);

    always_comb begin
        case (r_step)
            4'd0:    begin mul_a = 49'(r_c0);           mul_b = 18'(r_dx); end
            4'd1:    begin mul_a = 49'(r_s0);           mul_b = 18'(r_dy); end
            4'd2:    begin mul_a = 49'(r_s0);           mul_b = 18'(r_dx); end
            4'd3:    begin mul_a = 49'(r_c0);           mul_b = 18'(r_dy); end
            4'd4:    begin mul_a = $signed({1'b0, mag_x}); mul_b = $signed({6'd0, r_mpc[23:12]}); end
            4'd5:    begin mul_a = $signed({1'b0, mag_x}); mul_b = $signed({6'd0, r_mpc[11:0]}); end
            4'd6:    begin mul_a = $signed({1'b0, mag_y}); mul_b = $signed({6'd0, r_mpc[23:12]}); end
            4'd7:    begin mul_a = $signed({1'b0, mag_y}); mul_b = $signed({6'd0, r_mpc[11:0]}); end
            4'd8:    begin mul_a = 49'(r_sx);           mul_b = OFS_X_AMP_Q8; end
            4'd9:    begin mul_a = 49'(r_sy);           mul_b = OFS_Y_AMP_Q8; end
            default: begin mul_a = '0;                  mul_b = '0; end
        endcase
    end

    always_comb begin
        t1_rnd  = (r_t1 + 53'sd8192) >>> 14;
        t2_rnd  = (r_t2 + $signed(r_prod[52:0]) + 53'sd8192) >>> 14;
        wide    = {1'b0, r_p1, 12'd0} + {13'd0, r_prod[59:0]} + 73'd134217728;
        sc_new  = $signed({1'b0, wide[72:28]});
        off_rnd = (r_prod + 67'sd536870912) >>> 34;
        off_new = off_rnd[15:0];
        px      = 47'(r_sc_x) - 47'(r_off_x);
        py      = 47'(r_sc_y) - 47'(r_off_y);
    end

    function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
        if (v > 47'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -47'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= 4'd0;
            r_heading_now  <= '0;
            r_heading_prev <= '0;
            r_acc_x        <= RST_ACC_X;
            r_acc_y        <= RST_ACC_Y;
            r_mpc          <= RST_MM_PER_COUNT;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_prod  <= mul_a * mul_b;

            if (r_state == ST_IDLE && i_item_valid) begin
                if (i_item.kind == KIND_GYRO) begin
                    r_heading_now <= $signed(i_item.heading);
                end else begin
                    r_dx  <= $signed(i_item.dx);
                    r_dy  <= $signed(i_item.dy);
                    r_ang <= ang_main;
                end
            end
            if (cs_done) begin
                case (r_state)
                    ST_TRIG_MAIN: begin r_s0 <= cs_sin; r_c0 <= cs_cos; end
                    ST_TRIG_OX:   r_sx <= cs_sin;
                    ST_TRIG_OY:   r_sy <= cs_sin;
                    default:      ;
                endcase
            end

            if (r_state == ST_MUL) begin
                case (r_step)
                    4'd1: r_t1 <= r_prod[52:0];
                    4'd2: r_t1 <= r_t1 - r_prod[52:0];
                    4'd3: begin
                        r_t2    <= r_prod[52:0];
                        r_acc_x <= r_acc_x + t1_rnd[47:0];
                    end
                    4'd4: r_acc_y <= r_acc_y + t2_rnd[47:0];
                    4'd5: r_p1 <= r_prod[59:0];
                    4'd6: r_sc_x <= r_acc_x[47] ? -sc_new : sc_new;
                    4'd7: r_p1 <= r_prod[59:0];
                    4'd8: r_sc_y <= r_acc_y[47] ? -sc_new : sc_new;
                    4'd9: r_off_x <= off_new + OFS_X_BIAS_Q4;
                    4'd10: r_off_y <= off_new + OFS_Y_BIAS_Q4;
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_valid    <= 1'b1;
                r_out_x        <= sat32(px);
                r_out_y        <= sat32(py);
                r_out_h        <= r_heading_now;
                r_heading_prev <= r_heading_now;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_MM_PER_COUNT: r_mpc   <= i_cfg.data[23:0];
                    REG_START_X:      r_acc_x <= {i_cfg.data, 16'd0};
                    REG_START_Y:      r_acc_y <= {i_cfg.data, 16'd0};
                    default:          ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_h, r_out_y, r_out_x};

endmodule

// File: design/encoder_gyro_odometry.sv
// ----------------------------------------------------------------------------
// encoder_gyro_odometry
// Dead-reckoning x/y position from a two-wheel encoder pair and gyro heading.
// ----------------------------------------------------------------------------
// A gyro word (tuser 0) updates the stored heading and gives no output; it
// is popped from the queue once the processing side is idle. An encoder
// word (tuser 1) gives one output word, computed by three passes through
// the single iterative CORDIC unit and ten issues of the one shared
// multiplier. A two word queue sits between input and processing, and the
// output register holds a finished word while the next one is worked on.
// Configuration writes take effect at the next edge; a start-position
// write reloads the matching accumulator.
module encoder_gyro_odometry
    import ego_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // heading[16:0], count_x_raw, count_y_raw
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // pos_x, pos_y, pos_heading
);

    t_cfg_wr cfg;
    t_item   item;
    logic    item_valid, pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    ego_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item        (item),
        .o_item_valid  (item_valid),
        .i_pop         (pop)
    );

    ego_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: tb/encoder_gyro_odometry_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_gyro_odometry_test
// Drives gyro and encoder words into the odometry block, predicts each
// position word with an independent fixed-point model and compares the two.
// ----------------------------------------------------------------------------
module encoder_gyro_odometry_test;
    import ego_pkg::*;

    localparam int ITER = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [16:0] pos_heading;
    } t_pos;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(longint ang, output longint s, output longint c);
        longint r, x, y, z, xs, ys;
        bit flip;
        r = ang % 23592960;
        flip = 0;
        if (r < 0) r += 23592960;
        if (r >= 11796480) r -= 23592960;
        if (r > 5898240) begin
            r -= 11796480;
            flip = 1;
        end else if (r < -5898240) begin
            r += 11796480;
            flip = 1;
        end
        x = 652032875;
        y = 0;
        z = r;
        for (int i = 0; i < ITER && i < 24; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_q16(i[4:0]));
            end else begin
                x += ys; y -= xs; z += longint'(atan_q16(i[4:0]));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    class position_scoreboard;
        logic [15:0] center;
        logic [23:0] scale;
        longint hd_now, hd_prev, acc_x, acc_y;
        t_pos pending[$];
        int errors;

        function new();
            center = RST_COUNT_CENTER;
            scale = RST_MM_PER_COUNT;
            hd_now = 0; hd_prev = 0;
            acc_x = longint'(RST_ACC_X);
            acc_y = longint'(RST_ACC_Y);
            errors = 0;
        endfunction

        function longint wrap48(longint v);
            logic [47:0] t;
            t = v[47:0];
            return longint'(signed'(t));
        endfunction

        function longint scale_acc(longint acc);
            longint mag, q, mh, ml, p1, p2, low;
            mag = acc < 0 ? -acc : acc;
            mh = longint'(scale[23:12]);
            ml = longint'(scale[11:0]);
            p1 = mag * mh;
            p2 = mag * ml;
            low = ((p1 & 64'hFFFF) << 12) + p2 + (longint'(1) << 27);
            q = (p1 >>> 16) + (low >>> 28);
            return acc < 0 ? -q : q;
        endfunction

        function longint offset(longint ang, longint sh, longint amp, longint bias);
            longint s, c;
            sin_cos(ang - sh, s, c);
            return shr(amp * s + (longint'(1) << 29), 34) + bias;
        endfunction

        function logic [31:0] sat(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] d);
            case (idx)
                REG_COUNT_CENTER: center = d[15:0];
                REG_MM_PER_COUNT: scale = d[23:0];
                REG_START_X: acc_x = longint'(signed'(d)) * 65536;
                REG_START_Y: acc_y = longint'(signed'(d)) * 65536;
                default: ;
            endcase
        endfunction

        function void note_word(t_kind k, logic [16:0] hd, logic [15:0] cx, logic [15:0] cy);
            longint dx, dy, ang, s, c, px, py;
            t_pos p;
            if (k == KIND_GYRO) begin
                hd_now = longint'(signed'(hd));
                return;
            end
            dy = longint'(cy) - longint'(center);
            dx = longint'(center) - longint'(cx);
            ang = shr(hd_now + hd_prev, 1) * 256;
            sin_cos(ang, s, c);
            acc_x = wrap48(acc_x + shr(dx * c - dy * s + 8192, 14));
            acc_y = wrap48(acc_y + shr(dx * s + dy * c + 8192, 14));
            px = scale_acc(acc_x) - offset(ang, 4818384, 31168, 3932);
            py = scale_acc(acc_y) - offset(ang, 10316264, 30574, 542);
            p.pos_x = sat(px);
            p.pos_y = sat(py);
            p.pos_heading = hd_now[16:0];
            pending.push_back(p);
            hd_prev = hd_now;
        endfunction

        function void check_word(logic [87:0] d);
            t_pos want, got;
            got.pos_x = d[31:0];
            got.pos_y = d[63:32];
            got.pos_heading = d[80:64];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", d);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("exp x %0d y %0d h %0d, got x %0d y %0d h %0d",
                        want.pos_x, want.pos_y, want.pos_heading,
                        got.pos_x, got.pos_y, got.pos_heading);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we;
    logic [7:0] i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [55:0] s_axis_tdata;   // heading[16:0], count_x_raw, count_y_raw, pad
    logic m_axis_tvalid, m_axis_tready;
    logic [87:0] m_axis_tdata;   // pos_x, pos_y, pos_heading, pad

    position_scoreboard sb;
    int send_idle, recv_idle, cycles;

    encoder_gyro_odometry #(.TRIG_ITERATIONS(ITER)) uut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("encoder_gyro_odometry: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic cfg_write(logic [7:0] idx, logic [31:0] d);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_word(t_kind k, logic [16:0] hd, logic [15:0] cx, logic [15:0] cy);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= k;
        s_axis_tdata <= {7'd0, cy, cx, hd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(k, hd, cx, cy);
    endtask

    task automatic send_gyro(int h);
        send_word(KIND_GYRO, h[16:0], 16'($urandom), 16'($urandom));
    endtask

    task automatic send_enc(logic [15:0] cx, logic [15:0] cy);
        send_word(KIND_ENC, 17'($urandom), cx, cy);
    endtask

    task automatic random_words(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: send_gyro($urandom_range(131071));
                1, 2, 3: send_gyro(int'($urandom_range(92160)) - 46080);
                4: send_enc(16'($urandom), 16'($urandom));
                default: send_enc(16'(sb.center + $urandom_range(400) - 200),
                    16'(sb.center + $urandom_range(400) - 200));
            endcase
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        send_idle = 38; recv_idle = 70;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = 0; m_axis_tready = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes of fields, wrap of heading, both kinds
        send_enc(16'd30000, 16'd30000);
        send_enc(16'd0, 16'hffff);
        send_enc(16'hffff, 16'd0);
        send_gyro(46080); send_enc(16'd29000, 16'd31000);
        send_gyro(-46080); send_enc(16'd31000, 16'd29000);
        send_gyro(65535); send_gyro(-65536); send_enc(16'd0, 16'd0);
        send_gyro(23040); send_enc(16'hffff, 16'hffff);
        send_gyro(-23040); send_enc(16'd30100, 16'd29900);
        send_gyro(0); send_enc(16'd30000, 16'd30000);
        drain();
        // saturation: huge scale and far start
        cfg_write(REG_MM_PER_COUNT, 32'hffffff);
        cfg_write(REG_START_X, 32'h7fffffff);
        cfg_write(REG_START_Y, 32'h80000000);
        cfg_write(8'd9, 32'h12345678);
        send_enc(16'd0, 16'hffff); send_enc(16'hffff, 16'd0);
        drain();
        cfg_write(REG_COUNT_CENTER, 32'd0);
        cfg_write(REG_MM_PER_COUNT, 32'd0);
        send_enc(16'hffff, 16'hffff);
        drain();
        cfg_write(REG_COUNT_CENTER, 32'hffff);
        cfg_write(REG_MM_PER_COUNT, 32'd65536);
        cfg_write(REG_START_X, 32'd0);
        cfg_write(REG_START_Y, 32'd0);
        random_words(300);
        drain();
        send_idle = 70; recv_idle = 38;
        cfg_write(REG_COUNT_CENTER, $urandom);
        cfg_write(REG_MM_PER_COUNT, $urandom_range(200000));
        cfg_write(REG_START_X, $urandom);
        cfg_write(REG_START_Y, $urandom);
        random_words(300);
        drain();
        send_idle = 0; recv_idle = 0;
        cfg_write(REG_COUNT_CENTER, 32'd30000);
        cfg_write(REG_MM_PER_COUNT, $urandom);
        cfg_write(REG_START_X, 32'd3361);
        cfg_write(REG_START_Y, -32'sd331);
        random_words(300);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("encoder_gyro_odometry: match");
        else
            $display("encoder_gyro_odometry: mismatch");
        $finish;
    end
endmodule
